/* rtl/info_frame_byte_stuffer_defines.svh */
`ifndef INFO_FRAME_BYTE_STUFFER_DEFINES_SVH
`define INFO_FRAME_BYTE_STUFFER_DEFINES_SVH

// check a property on every clock edge outside reset
`define IFBS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ifbs assertion failed");

// check a property on every clock edge, reset included
`define IFBS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ifbs assertion failed");

`endif

/* rtl/ifbs_pkg.sv */
package ifbs_pkg;

   localparam logic [7:0] FLAG_BYTE     = 8'h5C;
   localparam logic [7:0] ESC_BYTE      = 8'h5D;
   localparam logic [7:0] ESC_FLAG_CODE = 8'h7C;
   localparam logic [7:0] ESC_ESC_CODE  = 8'h7D;
   localparam logic [7:0] ADDR_RESET    = 8'h03;
   localparam logic [7:0] CTRL_RESET    = 8'h80;

   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int CSR_ADDR_W          = 3;

   localparam logic REG_ADDRESS = 1'b0;
   localparam logic REG_CONTROL = 1'b1;

   typedef struct packed {
      logic       start;
      logic       last;
      logic [7:0] data;
      logic [7:0] check;
   } desc_type;

   typedef struct packed {
      logic [7:0] address;
      logic [7:0] control;
   } header_type;

   typedef enum logic [3:0] {
      STEP_BEGIN,
      STEP_HDR_FLAG,
      STEP_HDR_ADDR,
      STEP_HDR_CTRL,
      STEP_HDR_CHK,
      STEP_DATA,
      STEP_DATA_ESC,
      STEP_CHK,
      STEP_CHK_ESC,
      STEP_CLOSE
   } step_type;

   function automatic logic needs_escape(input logic [7:0] b);
      needs_escape = (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

   function automatic logic [7:0] escape_code(input logic [7:0] b);
      escape_code = (b == FLAG_BYTE) ? ESC_FLAG_CODE : ESC_ESC_CODE;
   endfunction

endpackage

/* rtl/ifbs_front.sv */
module ifbs_front
   import ifbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       queue_full,
   output logic       push,
   output desc_type   push_desc
);

   logic       in_frame_ff;
   logic       in_frame_in;
   logic [7:0] check_ff;
   logic [7:0] check_in;
   logic [7:0] check_new;
   logic       start;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;
   assign start      = !in_frame_ff;
   assign check_new  = (start ? 8'h00 : check_ff) ^ req_tdata;

   assign push_desc.start = start;
   assign push_desc.last  = req_tlast;
   assign push_desc.data  = req_tdata;
   assign push_desc.check = check_new;

   always_comb begin
      in_frame_in = in_frame_ff;
      check_in    = check_ff;
      if (push) begin
         in_frame_in = !req_tlast;
         check_in    = req_tlast ? 8'h00 : check_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         check_ff    <= 8'h00;
      end else begin
         in_frame_ff <= in_frame_in;
         check_ff    <= check_in;
      end
   end

endmodule

/* rtl/ifbs_queue.sv */
module ifbs_queue
   import ifbs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     full,
   output logic     head_valid,
   output desc_type head_desc
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type           entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

/* rtl/ifbs_back.sv */
module ifbs_back
   import ifbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  header_type header,
   input  logic       head_valid,
   input  desc_type   head_desc,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic       rsp_tuser
);

   step_type   step_ff;
   step_type   step_in;
   step_type   step_cur;
   logic       emit;
   logic       done;
   logic [7:0] byte_out;
   logic       close_out;
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       end_ff;

   assign step_cur = (step_ff == STEP_BEGIN) ?
                     (head_desc.start ? STEP_HDR_FLAG : STEP_DATA) : step_ff;
   assign emit     = head_valid && (!valid_ff || rsp_tready);
   assign pop      = emit && done;

   // next step of the expansion
   always_comb begin
      done    = 1'b0;
      step_in = step_ff;
      case (step_cur)
         STEP_HDR_FLAG: step_in = STEP_HDR_ADDR;
         STEP_HDR_ADDR: step_in = STEP_HDR_CTRL;
         STEP_HDR_CTRL: step_in = STEP_HDR_CHK;
         STEP_HDR_CHK:  step_in = STEP_DATA;
         STEP_DATA: begin
            if (needs_escape(head_desc.data)) begin
               step_in = STEP_DATA_ESC;
            end else if (head_desc.last) begin
               step_in = STEP_CHK;
            end else begin
               done = 1'b1;
            end
         end
         STEP_DATA_ESC: begin
            if (head_desc.last) begin
               step_in = STEP_CHK;
            end else begin
               done = 1'b1;
            end
         end
         STEP_CHK: step_in = needs_escape(head_desc.check) ? STEP_CHK_ESC : STEP_CLOSE;
         STEP_CHK_ESC: step_in = STEP_CLOSE;
         STEP_CLOSE: done = 1'b1;
         default: step_in = STEP_BEGIN;
      endcase
      if (done) begin
         step_in = STEP_BEGIN;
      end
   end

   // byte for the current step
   always_comb begin
      byte_out  = FLAG_BYTE;
      close_out = 1'b0;
      case (step_cur)
         STEP_HDR_FLAG: byte_out = FLAG_BYTE;
         STEP_HDR_ADDR: byte_out = header.address;
         STEP_HDR_CTRL: byte_out = header.control;
         STEP_HDR_CHK:  byte_out = header.address ^ header.control;
         STEP_DATA:
            byte_out = needs_escape(head_desc.data) ? ESC_BYTE : head_desc.data;
         STEP_DATA_ESC: byte_out = escape_code(head_desc.data);
         STEP_CHK:
            byte_out = needs_escape(head_desc.check) ? ESC_BYTE : head_desc.check;
         STEP_CHK_ESC: byte_out = escape_code(head_desc.check);
         STEP_CLOSE: begin
            byte_out  = FLAG_BYTE;
            close_out = 1'b1;
         end
         default: byte_out = FLAG_BYTE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_BEGIN;
         valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            step_ff <= step_in;
         end
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_out;
         last_ff <= done;
         end_ff  <= close_out;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = end_ff;

endmodule

/* rtl/info_frame_byte_stuffer.sv */
// channel   direction  handshake                 payload
// req_      in         req_tvalid / req_tready   tdata = data_byte, tlast = last_byte
// rsp_      out        rsp_tvalid / rsp_tready   tdata = out_byte, tlast = run_last,
//                                                tuser = frame_end
// csr_      in         APB psel/penable/pready   reg 0 address_byte @0x0, 1 control_byte @0x4
//
// One line byte leaves per cycle from the back sequencer while rsp_tready allows; an item
// costs 1 to 9 line bytes (header 4, payload 1-2, check 1-2, closing flag 1).
// The front accepts one item per cycle while the item queue (QUEUE_DEPTH) has room.
// Reset clears frame state, queue, sequencer and output; registers return to 0x03/0x80.
// rsp_tready low holds the output beat; the queue absorbs the front until full.
module info_frame_byte_stuffer
   import ifbs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_byte
   output logic                  rsp_tlast,
   output logic                  rsp_tuser,   // [0] frame_end
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   header_type header_ff;
   header_type header_in;
   logic       csr_write;
   logic       reg_index;
   logic       queue_full;
   logic       push;
   desc_type   push_desc;
   logic       pop;
   logic       head_valid;
   desc_type   head_desc;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[2];

   always_comb begin
      header_in = header_ff;
      if (csr_write) begin
         case (reg_index)
            REG_ADDRESS: header_in.address = csr_pwdata[7:0];
            REG_CONTROL: header_in.control = csr_pwdata[7:0];
            default:     header_in = header_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ADDRESS: csr_prdata = {24'h0, header_ff.address};
         REG_CONTROL: csr_prdata = {24'h0, header_ff.control};
         default:     csr_prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff.address <= ADDR_RESET;
         header_ff.control <= CTRL_RESET;
      end else begin
         header_ff <= header_in;
      end
   end

   ifbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_desc  (push_desc)
   );

   ifbs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   ifbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .header     (header_ff),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/ifbs_checker.sv */
`include "info_frame_byte_stuffer_defines.svh"

module ifbs_assert_checker
   import ifbs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   logic close_ok;

   assign close_ok = rsp_tlast && (rsp_tdata == FLAG_BYTE);

   `IFBS_ASSERT(rsp_valid_holds, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `IFBS_ASSERT(close_is_flag_and_last, clock, reset, rsp_tvalid && rsp_tuser |-> close_ok)
   `IFBS_ASSERT_ALWAYS(quiet_after_reset, clock, reset |=> !rsp_tvalid)

endmodule

bind info_frame_byte_stuffer ifbs_assert_checker u_checker (.*);
